// ----- sv/amfc_pkg.sv -----
`default_nettype none

package amfc_pkg;

    localparam int NUM_INPUT_CH = 8;
    localparam int CH_W         = 3;
    localparam int SAMPLE_W     = 16;
    localparam int MASK_W       = 8;
    localparam int COUNT_W      = 24;
    localparam int REG_IDX_W    = 2;
    localparam int REG_DATA_W   = 24;

    localparam logic [REG_IDX_W-1:0] REG_CHANNEL_MASK    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_COUNT     = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_CONTINUOUS_MODE = 2'd2;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_OVERRUN = 1'b1;

    localparam logic [MASK_W-1:0] MASK_RESET = 8'hFF;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic    action;
        logic    overlap;
        sample_t chan0;
        sample_t chan1;
        sample_t chan2;
        sample_t chan3;
        sample_t chan4;
        sample_t chan5;
        sample_t chan6;
        sample_t chan7;
    } item_t;

    typedef struct packed {
        logic            kind;
        logic [CH_W-1:0] channel;
        sample_t         sample_value;
        logic            last_in_frame;
        logic            capture_done;
    } result_t;

endpackage

`default_nettype wire

// ----- sv/amfc_item_if.sv -----
`default_nettype none

interface amfc_item_if;
    logic                valid;
    logic                ready;
    amfc_pkg::item_t     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/amfc_result_if.sv -----
`default_nettype none

interface amfc_result_if;
    logic                valid;
    logic                ready;
    amfc_pkg::result_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/adc_masked_frame_capture.sv -----
// Channel  | Dir | Payload                                          | Beats per item
// ---------+-----+--------------------------------------------------+---------------
// item     | in  | action, overlap, chan0..chan7                    | 1
// result   | out | kind, channel, sample_value, last_in_frame, done | 0, 1 or up to 8
// wr_*     | in  | wr_index, wr_data (channel_mask, frame_count, mode) | 1
//
// An item is decoded and its state update applied in the cycle it is accepted.
// Its results leave one beat per cycle, while result.ready holds, through a single
// output register, which loads a new beat whenever it is empty or being taken.
// The next item is taken in the cycle its predecessor's last beat is loaded.
// Reset restores the register defaults, clears the counter, flag and stored frame.
// A stalled result holds the output register and the frame in flight.
`default_nettype none

module adc_masked_frame_capture #(
    parameter int NUM_CHANNELS = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    amfc_item_if.sink                                item,
    amfc_result_if.source                            result,
    input  wire logic                                wr_en,
    input  wire logic [amfc_pkg::REG_IDX_W-1:0]      wr_index,
    input  wire logic [amfc_pkg::REG_DATA_W-1:0]     wr_data
);

    localparam int CHAN_LIMIT = (NUM_CHANNELS < amfc_pkg::NUM_INPUT_CH) ?
                                NUM_CHANNELS : amfc_pkg::NUM_INPUT_CH;
    localparam logic [amfc_pkg::MASK_W-1:0] LIMIT_MASK =
        amfc_pkg::MASK_W'((9'd1 << CHAN_LIMIT) - 9'd1);

    logic [amfc_pkg::MASK_W-1:0]   channel_mask_reg;
    logic [amfc_pkg::COUNT_W-1:0]  frame_count_reg;
    logic                          continuous_mode_reg;

    logic [amfc_pkg::COUNT_W-1:0]  frames_left_reg, frames_left_next;
    logic                          overrun_seen_reg, overrun_seen_next;
    amfc_pkg::sample_t             prev_frame_reg [amfc_pkg::NUM_INPUT_CH];
    amfc_pkg::sample_t             prev_frame_next [amfc_pkg::NUM_INPUT_CH];

    amfc_pkg::sample_t             job_frame_reg [amfc_pkg::NUM_INPUT_CH];
    amfc_pkg::sample_t             job_frame_next [amfc_pkg::NUM_INPUT_CH];
    logic [amfc_pkg::MASK_W-1:0]   job_bits_reg, job_bits_next;
    logic                          job_ovr_reg, job_ovr_next;
    logic                          job_done_reg, job_done_next;

    amfc_pkg::result_t             out_data_reg, out_data_next;
    logic                          out_valid_reg, out_valid_next;

    amfc_pkg::sample_t             cur_frame [amfc_pkg::NUM_INPUT_CH];
    logic [amfc_pkg::CH_W-1:0]     sel;
    logic [amfc_pkg::MASK_W-1:0]   remaining;
    logic                          job_active;
    logic                          last_beat;
    logic                          out_load;
    logic                          emit;
    logic                          item_fire;

    assign cur_frame[0] = item.data.chan0;
    assign cur_frame[1] = item.data.chan1;
    assign cur_frame[2] = item.data.chan2;
    assign cur_frame[3] = item.data.chan3;
    assign cur_frame[4] = item.data.chan4;
    assign cur_frame[5] = item.data.chan5;
    assign cur_frame[6] = item.data.chan6;
    assign cur_frame[7] = item.data.chan7;

    // pick lowest pending channel
    always_comb
    begin
        sel = '0;
        for (int i = amfc_pkg::NUM_INPUT_CH - 1; i >= 0; i--)
        begin
            if (job_bits_reg[i])
            begin
                sel = amfc_pkg::CH_W'(i);
            end
        end
    end

    assign remaining  = job_bits_reg & (job_bits_reg - amfc_pkg::MASK_W'(1));
    assign job_active = job_ovr_reg || (job_bits_reg != '0);
    assign last_beat  = job_ovr_reg || (remaining == '0);
    assign out_load   = !out_valid_reg || result.ready;
    assign emit       = job_active && out_load;
    assign item.ready = !job_active || (out_load && last_beat);
    assign item_fire  = item.valid && item.ready;

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    always_comb
    begin
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            if (job_ovr_reg)
            begin
                out_data_next.kind          = amfc_pkg::KIND_OVERRUN;
                out_data_next.channel       = '0;
                out_data_next.sample_value  = '0;
                out_data_next.last_in_frame = 1'b1;
                out_data_next.capture_done  = 1'b0;
            end
            else
            begin
                out_data_next.kind          = amfc_pkg::KIND_SAMPLE;
                out_data_next.channel       = sel;
                out_data_next.sample_value  = job_frame_reg[sel];
                out_data_next.last_in_frame = last_beat;
                out_data_next.capture_done  = job_done_reg && last_beat;
            end
        end
        else if (out_load)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        frames_left_next  = frames_left_reg;
        overrun_seen_next = overrun_seen_reg;
        prev_frame_next   = prev_frame_reg;
        job_frame_next    = job_frame_reg;
        job_bits_next     = job_bits_reg;
        job_ovr_next      = job_ovr_reg;
        job_done_next     = job_done_reg;

        if (emit)
        begin
            job_bits_next = job_ovr_reg ? job_bits_reg : remaining;
            job_ovr_next  = 1'b0;
        end

        if (item_fire)
        begin
            unique case (item.data.action)
                amfc_pkg::ACT_START:
                begin
                    frames_left_next  = frame_count_reg;
                    overrun_seen_next = 1'b0;
                end
                amfc_pkg::ACT_TICK:
                begin
                    if (item.data.overlap)
                    begin
                        overrun_seen_next = 1'b1;
                        if (!continuous_mode_reg)
                        begin
                            frames_left_next = '0;
                        end
                        job_ovr_next  = 1'b1;
                        job_bits_next = '0;
                    end
                    else if (continuous_mode_reg)
                    begin
                        job_frame_next  = prev_frame_reg;
                        job_bits_next   = channel_mask_reg & LIMIT_MASK;
                        job_done_next   = 1'b0;
                        prev_frame_next = cur_frame;
                    end
                    else if (frames_left_reg != '0)
                    begin
                        frames_left_next = frames_left_reg - amfc_pkg::COUNT_W'(1);
                        job_frame_next   = cur_frame;
                        job_bits_next    = channel_mask_reg & LIMIT_MASK;
                        job_done_next    = (frames_left_reg == amfc_pkg::COUNT_W'(1));
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_mask_reg    <= amfc_pkg::MASK_RESET;
            frame_count_reg     <= '0;
            continuous_mode_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                amfc_pkg::REG_CHANNEL_MASK:
                    channel_mask_reg <= wr_data[amfc_pkg::MASK_W-1:0];
                amfc_pkg::REG_FRAME_COUNT:
                    frame_count_reg <= wr_data[amfc_pkg::COUNT_W-1:0];
                amfc_pkg::REG_CONTINUOUS_MODE:
                    continuous_mode_reg <= wr_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_left_reg  <= '0;
            overrun_seen_reg <= 1'b0;
            job_bits_reg     <= '0;
            job_ovr_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < amfc_pkg::NUM_INPUT_CH; i++)
            begin
                prev_frame_reg[i] <= '0;
            end
        end
        else
        begin
            frames_left_reg  <= frames_left_next;
            overrun_seen_reg <= overrun_seen_next;
            job_bits_reg     <= job_bits_next;
            job_ovr_reg      <= job_ovr_next;
            out_valid_reg    <= out_valid_next;
            prev_frame_reg   <= prev_frame_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_frame_reg <= job_frame_next;
        job_done_reg  <= job_done_next;
        out_data_reg  <= out_data_next;
    end

endmodule

`default_nettype wire

// ----- sv/amfc_checker.sv -----
`default_nettype none

module amfc_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          result_valid,
    input wire logic                          result_ready,
    input wire amfc_pkg::result_t             result_data
);

    logic result_fire;

    assign result_fire = result_valid && result_ready;

    // hold a stalled beat
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("result beat changed while stalled");

    a_overrun_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_data.kind == amfc_pkg::KIND_OVERRUN) |->
            result_data.last_in_frame && !result_data.capture_done &&
            (result_data.channel == '0) && (result_data.sample_value == '0))
        else $error("malformed overrun beat");

    a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.capture_done |->
            result_data.last_in_frame && (result_data.kind == amfc_pkg::KIND_SAMPLE))
        else $error("capture done outside last sample of frame");

    // advance without gaps inside a frame
    a_frame_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_fire && !result_data.last_in_frame |=>
            result_valid && (result_data.kind == amfc_pkg::KIND_SAMPLE) &&
            (result_data.channel > $past(result_data.channel)))
        else $error("frame beats not contiguous or not ascending");

endmodule

bind adc_masked_frame_capture amfc_checker u_amfc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_data  (result.data)
);

`default_nettype wire
